@@ rtl/tmd_pkg.sv @@
// tape machine datapath package: sizes, operation and status codes, word types
// shared by every module of the tape machine datapath but tmd_ram; depends on nothing
package tmd_pkg;

   localparam int TAPE_DEPTH = 4096;
   localparam int ADDR_W     = $clog2(TAPE_DEPTH);
   localparam int LIM_W      = ADDR_W + 1;
   localparam int CFG_W      = 13;
   localparam int PTR_W      = 12;
   localparam int AMT_W      = 32;
   localparam int SUM_W      = AMT_W + 2;
   localparam int BYTE_W     = 8;
   localparam int KIND_W     = 3;
   localparam int STATUS_W   = 2;

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4096);

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // instruction kinds
   localparam logic [KIND_W-1:0] KIND_SHIFT  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ADD    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_MOVE   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_OUTPUT = 3'd4;
   localparam logic [KIND_W-1:0] KIND_INPUT  = 3'd5;
   localparam logic [KIND_W-1:0] KIND_LOOP   = 3'd6;
   localparam logic [KIND_W-1:0] KIND_HALT   = 3'd7;

   // result status
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_PTR_OOR  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MOVE_OOR = 2'd2;
   localparam logic [STATUS_W-1:0] ST_HALTED   = 2'd3;

   // back end operations
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_NONE  = 3'd0;
   localparam logic [OP_W-1:0] OP_WRITE = 3'd1;
   localparam logic [OP_W-1:0] OP_ADD   = 3'd2;
   localparam logic [OP_W-1:0] OP_OUT   = 3'd3;
   localparam logic [OP_W-1:0] OP_LOOP  = 3'd4;
   localparam logic [OP_W-1:0] OP_MOVE  = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]     op;
      logic [ADDR_W-1:0]   addr;
      logic [ADDR_W-1:0]   tgt_addr;
      logic [BYTE_W-1:0]   data;
      logic [STATUS_W-1:0] status;
      logic [PTR_W-1:0]    pointer_now;
   } op_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                out_valid;
      logic [BYTE_W-1:0]   out_byte;
      logic                skip_loop;
      logic [PTR_W-1:0]    pointer_now;
   } rsp_type;

endpackage

@@ rtl/tmd_ram.sv @@
// generic single write port, single read port ram with registered read
// stand-alone, no package
module tmd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/tmd_front.sv @@
// front end: limit register, cell pointer, halt flag, range checks, decode to ops
// uses tmd_pkg
module tmd_front import tmd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CFG_W-1:0]         csr_wr_data,
   input  logic                     req_push,
   output logic                     req_full,
   input  logic [KIND_W-1:0]        req_kind,
   input  logic signed [AMT_W-1:0]  req_amount,
   input  logic [BYTE_W-1:0]        req_input_byte,
   input  logic                     clearing,
   input  logic                     op_full,
   output logic                     op_push,
   output op_type                   op_data
);

   logic [CFG_W-1:0]  cfg_ff, cfg_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic              halted_ff, halted_in;
   logic [LIM_W-1:0]  lim;
   logic [SUM_W-1:0]  sum;
   logic              oor;
   logic              accept;

   assign req_full = clearing || op_full;
   assign accept   = req_push && !req_full;
   assign op_push  = accept;

   always_comb begin
      if (cfg_ff == '0) begin
         lim = LIM_W'(1);
      end else if (32'(cfg_ff) > 32'(TAPE_DEPTH)) begin
         lim = LIM_W'(TAPE_DEPTH);
      end else begin
         lim = LIM_W'(cfg_ff);
      end
   end

   // pointer plus signed distance, sign held in the top bit
   assign sum = {{(SUM_W-AMT_W){req_amount[AMT_W-1]}}, req_amount} + SUM_W'(ptr_ff);
   assign oor = sum[SUM_W-1] || (sum >= SUM_W'(lim));

   assign cfg_in = csr_wr_en ? csr_wr_data : cfg_ff;

   always_comb begin
      ptr_in             = ptr_ff;
      halted_in          = halted_ff;
      op_data.op         = OP_NONE;
      op_data.addr       = ptr_ff;
      op_data.tgt_addr   = sum[ADDR_W-1:0];
      op_data.data       = '0;
      op_data.status     = ST_OK;
      if (halted_ff) begin
         op_data.status = ST_HALTED;
      end else begin
         case (req_kind)
            KIND_SHIFT: begin
               if (oor) begin
                  op_data.status = ST_PTR_OOR;
               end else begin
                  ptr_in = sum[ADDR_W-1:0];
               end
            end
            KIND_ADD: begin
               op_data.op   = OP_ADD;
               op_data.data = req_amount[BYTE_W-1:0];
            end
            KIND_CLEAR: begin
               op_data.op = OP_WRITE;
            end
            KIND_MOVE: begin
               if (oor) begin
                  op_data.status = ST_MOVE_OOR;
               end else begin
                  op_data.op = OP_MOVE;
               end
            end
            KIND_OUTPUT: begin
               op_data.op = OP_OUT;
            end
            KIND_INPUT: begin
               op_data.op   = OP_WRITE;
               op_data.data = req_input_byte;
            end
            KIND_LOOP: begin
               op_data.op = OP_LOOP;
            end
            default: begin
               halted_in      = 1'b1;
               op_data.status = ST_HALTED;
            end
         endcase
      end
      op_data.pointer_now = PTR_W'(ptr_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff    <= CFG_RESET;
         ptr_ff    <= '0;
         halted_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         if (accept) begin
            ptr_ff    <= ptr_in;
            halted_ff <= halted_in;
         end
      end
   end

endmodule

@@ rtl/tmd_op_queue.sv @@
// short queue of decoded op words between front and back end
// uses tmd_pkg
module tmd_op_queue import tmd_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_data,
   output logic   full,
   input  logic   pop,
   output logic   empty,
   output op_type head
);

   op_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff;
   logic                   do_push, do_pop;

   assign full    = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

@@ rtl/tmd_back.sv @@
// back end: tape ram sequencer, tape clearing sweep after reset, result queue
// uses tmd_pkg and tmd_ram
module tmd_back import tmd_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   output logic   clearing,
   input  logic   op_empty,
   input  op_type op_head,
   output logic   op_pop,
   output logic   rsp_empty,
   input  logic   rsp_pop,
   output rsp_type rsp_head
);

   localparam logic [2:0] S_CLEARING = 3'd0;
   localparam logic [2:0] S_IDLE     = 3'd1;
   localparam logic [2:0] S_SRC      = 3'd2;
   localparam logic [2:0] S_TGT      = 3'd3;
   localparam logic [2:0] S_CLR      = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   op_type            cur_ff, cur_in;
   logic [BYTE_W-1:0] src_ff, src_in;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [BYTE_W-1:0] wr_data, rd_data;

   logic              rsp_push, rsp_full;
   rsp_type           rsp_new;

   rsp_type                rq_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] rq_wr_ff, rq_rd_ff;
   logic [QUEUE_CNT_W-1:0] rq_cnt_ff;
   logic                   rq_pop;

   tmd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (TAPE_DEPTH)
   ) u_tape (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign clearing = state_ff == S_CLEARING;
   assign rd_addr  = (state_ff == S_SRC) ? cur_ff.tgt_addr : op_head.addr;

   always_comb begin
      state_in    = state_ff;
      clr_cnt_in  = clr_cnt_ff;
      cur_in      = cur_ff;
      src_in      = src_ff;
      op_pop      = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = cur_ff.addr;
      wr_data     = '0;
      rsp_push    = 1'b0;
      rsp_new.status      = cur_ff.status;
      rsp_new.out_valid   = 1'b0;
      rsp_new.out_byte    = '0;
      rsp_new.skip_loop   = 1'b0;
      rsp_new.pointer_now = cur_ff.pointer_now;
      case (state_ff)
         S_CLEARING: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ADDR_W'(TAPE_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (!op_empty && !rsp_full) begin
               op_pop = 1'b1;
               cur_in = op_head;
               rsp_new.status      = op_head.status;
               rsp_new.pointer_now = op_head.pointer_now;
               case (op_head.op)
                  OP_NONE: begin
                     rsp_push = 1'b1;
                  end
                  OP_WRITE: begin
                     wr_en    = 1'b1;
                     wr_addr  = op_head.addr;
                     wr_data  = op_head.data;
                     rsp_push = 1'b1;
                  end
                  default: begin
                     state_in = S_SRC;
                  end
               endcase
            end
         end
         S_SRC: begin
            case (cur_ff.op)
               OP_ADD: begin
                  wr_en    = 1'b1;
                  wr_data  = rd_data + cur_ff.data;
                  rsp_push = 1'b1;
                  state_in = S_IDLE;
               end
               OP_OUT: begin
                  rsp_new.out_valid = 1'b1;
                  rsp_new.out_byte  = rd_data;
                  rsp_push          = 1'b1;
                  state_in          = S_IDLE;
               end
               OP_LOOP: begin
                  rsp_new.skip_loop = rd_data == '0;
                  rsp_push          = 1'b1;
                  state_in          = S_IDLE;
               end
               OP_MOVE: begin
                  src_in   = rd_data;
                  state_in = S_TGT;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_TGT: begin
            // target gains the source value
            wr_en    = 1'b1;
            wr_addr  = cur_ff.tgt_addr;
            wr_data  = rd_data + src_ff;
            state_in = S_CLR;
         end
         S_CLR: begin
            // source cleared last, so a zero offset ends at zero
            wr_en    = 1'b1;
            rsp_push = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEARING;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      src_ff <= src_in;
   end

   // result queue
   assign rsp_full  = rq_cnt_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign rsp_empty = rq_cnt_ff == '0;
   assign rq_pop    = rsp_pop && !rsp_empty;
   assign rsp_head  = rq_ff[rq_rd_ff];

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         rq_ff[rq_wr_ff] <= rsp_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff  <= '0;
         rq_rd_ff  <= '0;
         rq_cnt_ff <= '0;
      end else begin
         if (rsp_push) begin
            rq_wr_ff <= (rq_wr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rq_wr_ff + 1'b1;
         end
         if (rq_pop) begin
            rq_rd_ff <= (rq_rd_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rq_rd_ff + 1'b1;
         end
         if (rsp_push && !rq_pop) begin
            rq_cnt_ff <= rq_cnt_ff + 1'b1;
         end else if (rq_pop && !rsp_push) begin
            rq_cnt_ff <= rq_cnt_ff - 1'b1;
         end
      end
   end

endmodule

@@ rtl/tape_machine_datapath_top.sv @@
// tape machine datapath top: front end, op queue, back end with tape ram
// uses tmd_pkg, tmd_front, tmd_op_queue, tmd_back
// path: each word passes the op queue, then the result queue; shift, halt, range
//    errors, clear and input go straight from S_IDLE; add, output and loop test
//    pass S_SRC, a move S_SRC, S_TGT, S_CLR; a new op starts only from S_IDLE
// reset: synchronous; afterwards a sweep zeroes all 4096 tape cells, full held high
module tape_machine_datapath_top import tmd_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [CFG_W-1:0]        csr_wr_data,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [KIND_W-1:0]       req_kind,
   input  logic signed [AMT_W-1:0] req_amount,
   input  logic [BYTE_W-1:0]       req_input_byte,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic                    rsp_out_valid,
   output logic [BYTE_W-1:0]       rsp_out_byte,
   output logic                    rsp_skip_loop,
   output logic [PTR_W-1:0]        rsp_pointer_now
);

   logic    clearing;
   logic    op_push, op_full, op_pop, op_empty;
   op_type  op_data, op_head;
   rsp_type rsp_head;

   tmd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_kind       (req_kind),
      .req_amount     (req_amount),
      .req_input_byte (req_input_byte),
      .clearing       (clearing),
      .op_full        (op_full),
      .op_push        (op_push),
      .op_data        (op_data)
   );

   tmd_op_queue u_op_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_data (op_data),
      .full      (op_full),
      .pop       (op_pop),
      .empty     (op_empty),
      .head      (op_head)
   );

   tmd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .clearing  (clearing),
      .op_empty  (op_empty),
      .op_head   (op_head),
      .op_pop    (op_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_head  (rsp_head)
   );

   assign rsp_status      = rsp_head.status;
   assign rsp_out_valid   = rsp_head.out_valid;
   assign rsp_out_byte    = rsp_head.out_byte;
   assign rsp_skip_loop   = rsp_head.skip_loop;
   assign rsp_pointer_now = rsp_head.pointer_now;

endmodule
